// ===== hdl/tfn_pkg.sv =====
// Shared types and constants of the triangle face normal block.
// No dependencies; used by tfn_cross, tfn_sumsq, tfn_step and the top level.
package tfn_pkg;

	localparam int FIELD_W     = 16;
	localparam int IN_FIELDS   = 9;
	localparam int OUT_FIELDS  = 3;
	localparam int IN_TDATA_W  = FIELD_W * IN_FIELDS;
	localparam int OUT_TDATA_W = FIELD_W * OUT_FIELDS;

	// per-item tag carried beside the datapath
	typedef struct packed {
		logic       degen;
		logic [2:0] neg;
	} tag_t;

endpackage

// ===== hdl/tfn_cross.sv =====
// Edge vectors and cross product of one triangle, three pipeline stages.
// Uses tfn_pkg for field layout and the tag type.
module tfn_cross #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic [2:0]                           en,
	input  logic [tfn_pkg::IN_TDATA_W-1:0]       in_data,
	output logic [2:0][2*COORD_WIDTH+1:0]        mag,
	output logic [2:0]                           neg
);
	localparam int CW   = COORD_WIDTH;
	localparam int EW   = CW + 1;
	localparam int PW   = 2 * EW;
	localparam int XW   = PW + 1;
	localparam int MW   = 2 * CW + 2;
	localparam int RAWW = (CW > tfn_pkg::FIELD_W) ? CW : tfn_pkg::FIELD_W;

	logic signed [CW-1:0] crd [9];
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic [2:0][MW-1:0]   mag_s3;
	logic [2:0]           neg_s3;

	always_comb begin
		logic [RAWW-1:0] raw;
		for (int i = 0; i < 9; i++) begin
			raw = RAWW'(in_data[tfn_pkg::FIELD_W*i +: tfn_pkg::FIELD_W]);
			crd[i] = $signed(raw[CW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'(crd[3+i]) - EW'(crd[i]);
				e2_s1[i] <= EW'(crd[6+i]) - EW'(crd[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [XW-1:0] c;
		logic signed [XW-1:0] a;
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				c = XW'(p_s2[2*i]) - XW'(p_s2[2*i+1]);
				a = c[XW-1] ? -c : c;
				neg_s3[i] <= c[XW-1];
				mag_s3[i] <= a[MW-1:0];
			end
		end
	end

	assign mag = mag_s3;
	assign neg = neg_s3;

endmodule

// ===== hdl/tfn_sumsq.sv =====
// Squares of the cross product (split into half-width partial products),
// their sum and the start values of the rounding search. Four stages.
module tfn_sumsq #(
	parameter int COORD_WIDTH      = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                                   clk,
	input  logic [3:0]                             en,
	input  logic [2:0][2*COORD_WIDTH+1:0]          mag,
	input  logic [2:0]                             neg,
	output logic [4*COORD_WIDTH+5:0]               sum,
	output logic [2:0][4*COORD_WIDTH+2*NORMAL_FRAC_BITS+11:0] rem,
	output logic [2:0][4*COORD_WIDTH+NORMAL_FRAC_BITS+9:0]    vacc,
	output tfn_pkg::tag_t                          tag
);
	localparam int F  = NORMAL_FRAC_BITS;
	localparam int MW = 2 * COORD_WIDTH + 2;
	localparam int SW = 2 * MW + 2;
	localparam int RW = SW + 2 * F + 6;
	localparam int VW = SW + F + 4;
	localparam int H  = (MW + 1) / 2;
	localparam int LW = MW - H;

	logic [2:0][2*LW-1:0]   hh_s4;
	logic [2:0][LW+H-1:0]   hl_s4;
	logic [2:0][2*H-1:0]    ll_s4;
	logic [2:0]             neg_s4, neg_s5, neg_s6;
	logic [2:0][2*MW-1:0]   sq_s5, sq_s6;
	logic [SW-1:0]          sum_s6, sum_s7;
	logic [2:0][RW-1:0]     rem_s7;
	logic [2:0][VW-1:0]     vacc_s7;
	tfn_pkg::tag_t          tag_s7;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				hh_s4[i] <= mag[i][MW-1:H] * mag[i][MW-1:H];
				hl_s4[i] <= mag[i][MW-1:H] * mag[i][H-1:0];
				ll_s4[i] <= mag[i][H-1:0] * mag[i][H-1:0];
			end
			neg_s4 <= neg;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++)
				sq_s5[i] <= ((2*MW)'(hh_s4[i]) << (2*H)) + ((2*MW)'(hl_s4[i]) << (H+1))
					+ (2*MW)'(ll_s4[i]);
			neg_s5 <= neg_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sum_s6 <= SW'(sq_s5[0]) + SW'(sq_s5[1]) + SW'(sq_s5[2]);
			sq_s6  <= sq_s5;
			neg_s6 <= neg_s5;
		end
	end

	// search starts at q = 0: remainder T - S, accumulator (2q-1)*S = -S
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				rem_s7[i]  <= (RW'(sq_s6[i]) << (2*F+2)) - RW'(sum_s6);
				vacc_s7[i] <= -VW'(sum_s6);
			end
			sum_s7       <= sum_s6;
			tag_s7.degen <= (sum_s6 == '0);
			tag_s7.neg   <= neg_s6;
		end
	end

	assign sum  = sum_s7;
	assign rem  = rem_s7;
	assign vacc = vacc_s7;
	assign tag  = tag_s7;

endmodule

// ===== hdl/tfn_step.sv =====
// One bit of the rounded normalization search, for all three components.
// Decides bit STEP_BIT of q from a shift-and-add remainder update. Uses tfn_pkg.
module tfn_step #(
	parameter int COORD_WIDTH      = 16,
	parameter int NORMAL_FRAC_BITS = 14,
	parameter int STEP_BIT         = 0
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [4*COORD_WIDTH+5:0]               sum_in,
	input  logic [2:0][4*COORD_WIDTH+2*NORMAL_FRAC_BITS+11:0] rem_in,
	input  logic [2:0][4*COORD_WIDTH+NORMAL_FRAC_BITS+9:0]    vacc_in,
	input  logic [2:0][NORMAL_FRAC_BITS:0]         q_in,
	input  tfn_pkg::tag_t                          tag_in,
	output logic [4*COORD_WIDTH+5:0]               sum_out,
	output logic [2:0][4*COORD_WIDTH+2*NORMAL_FRAC_BITS+11:0] rem_out,
	output logic [2:0][4*COORD_WIDTH+NORMAL_FRAC_BITS+9:0]    vacc_out,
	output logic [2:0][NORMAL_FRAC_BITS:0]         q_out,
	output tfn_pkg::tag_t                          tag_out
);
	localparam int F  = NORMAL_FRAC_BITS;
	localparam int K  = STEP_BIT;
	localparam int MW = 2 * COORD_WIDTH + 2;
	localparam int SW = 2 * MW + 2;
	localparam int RW = SW + 2 * F + 6;
	localparam int VW = SW + F + 4;
	localparam int QW = F + 1;

	logic [SW-1:0]      sum_q;
	logic [2:0][RW-1:0] rem_q;
	logic [2:0][VW-1:0] vacc_q;
	logic [2:0][QW-1:0] qv_q;
	tfn_pkg::tag_t      tag_q;

	// raising q by d=2^K grows (2q-1)^2*S by 4d*(2q-1)*S + 4d^2*S
	always_ff @(posedge clk) begin
		logic signed [RW-1:0] vx;
		logic [RW-1:0]        delta;
		logic [RW-1:0]        cand;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vx    = RW'($signed(vacc_in[i]));
				delta = RW'(vx <<< (K+2)) + (RW'(sum_in) << (2*K+2));
				cand  = rem_in[i] - delta;
				if (!cand[RW-1]) begin
					rem_q[i]  <= cand;
					vacc_q[i] <= vacc_in[i] + (VW'(sum_in) << (K+1));
					qv_q[i]   <= q_in[i] | (QW'(1) << K);
				end else begin
					rem_q[i]  <= rem_in[i];
					vacc_q[i] <= vacc_in[i];
					qv_q[i]   <= q_in[i];
				end
			end
			sum_q <= sum_in;
			tag_q <= tag_in;
		end
	end

	assign sum_out  = sum_q;
	assign rem_out  = rem_q;
	assign vacc_out = vacc_q;
	assign q_out    = qv_q;
	assign tag_out  = tag_q;

endmodule

// ===== hdl/triangle_face_normal.sv =====
// Triangle unit face normal: top level, stream ports and pipeline control.
// Instantiates tfn_cross, tfn_sumsq and tfn_step; uses tfn_pkg.
//
// Usage:
//  s_* channel takes one triangle per item: nine 16-bit signed vertex
//  coordinates. The low COORD_WIDTH bits of each field are the coordinate.
//  m_* channel gives one item per triangle: the unit normal in signed
//  fixed point with NORMAL_FRAC_BITS fraction bits, each component equal to
//  c*2^F/|c| rounded to nearest, ties away from zero; m_tuser flags a
//  degenerate triangle (zero cross product), whose normal reads as zero.
//  From acceptance to m_tvalid an item passes three stages of cross
//  product, four of squaring and sums, one stage per bit of the rounding
//  search and one output register. Throughput is one item per cycle while
//  m_tready holds; every stage is a register with its own valid bit, and
//  the search decides one result bit per stage.
//  When the receiver stalls, the output holds and stages behind it fill up;
//  s_tready falls only when every stage holds an item.
//  Reset clears all valid bits; the pipeline then accepts at once.
module triangle_face_normal #(
	parameter int COORD_WIDTH      = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z
	input  logic [tfn_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// normal_x, normal_y, normal_z
	output logic [tfn_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// degenerate
	output logic                                m_tuser
);
	localparam int F   = NORMAL_FRAC_BITS;
	localparam int MW  = 2 * COORD_WIDTH + 2;
	localparam int SW  = 2 * MW + 2;
	localparam int RW  = SW + 2 * F + 6;
	localparam int VW  = SW + F + 4;
	localparam int QW  = F + 1;
	localparam int NST = F + 9;
	localparam int FW  = tfn_pkg::FIELD_W;

	logic [NST:1]       vld_q;
	logic [NST:1]       en;
	logic [2:0][MW-1:0] mag;
	logic [2:0]         neg;

	logic [SW-1:0]      sum_st  [0:F+1];
	logic [2:0][RW-1:0] rem_st  [0:F+1];
	logic [2:0][VW-1:0] vacc_st [0:F+1];
	logic [2:0][QW-1:0] q_st    [0:F+1];
	tfn_pkg::tag_t      tag_st  [0:F+1];

	logic [tfn_pkg::OUT_TDATA_W-1:0] tdata_q;
	logic                            tuser_q;

	// a stage loads when empty or when the one ahead moves
	always_comb begin
		en[NST] = !vld_q[NST] || m_tready;
		for (int k = NST - 1; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= s_tvalid;
			for (int k = 2; k <= NST; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	tfn_cross #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_cross (
		.clk    (clk),
		.en     (en[3:1]),
		.in_data(s_tdata),
		.mag    (mag),
		.neg    (neg)
	);

	tfn_sumsq #(
		.COORD_WIDTH     (COORD_WIDTH),
		.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
	) u_sumsq (
		.clk (clk),
		.en  (en[7:4]),
		.mag (mag),
		.neg (neg),
		.sum (sum_st[0]),
		.rem (rem_st[0]),
		.vacc(vacc_st[0]),
		.tag (tag_st[0])
	);

	assign q_st[0] = '0;

	for (genvar j = 0; j <= F; j++) begin : g_step
		tfn_step #(
			.COORD_WIDTH     (COORD_WIDTH),
			.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS),
			.STEP_BIT        (F - j)
		) u_step (
			.clk     (clk),
			.en      (en[8+j]),
			.sum_in  (sum_st[j]),
			.rem_in  (rem_st[j]),
			.vacc_in (vacc_st[j]),
			.q_in    (q_st[j]),
			.tag_in  (tag_st[j]),
			.sum_out (sum_st[j+1]),
			.rem_out (rem_st[j+1]),
			.vacc_out(vacc_st[j+1]),
			.q_out   (q_st[j+1]),
			.tag_out (tag_st[j+1])
		);
	end

	// sign and field masking; degenerate forces zero
	always_ff @(posedge clk) begin
		logic signed [31:0] val;
		if (en[NST]) begin
			for (int i = 0; i < 3; i++) begin
				val = $signed(32'(q_st[F+1][i]));
				if (tag_st[F+1].neg[i])
					val = -val;
				if (tag_st[F+1].degen)
					val = '0;
				tdata_q[FW*i +: FW] <= val[FW-1:0];
			end
			tuser_q <= tag_st[F+1].degen;
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[NST];
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate item with nonzero normal");

	a_nondegen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && (NORMAL_FRAC_BITS < 15) |-> m_tdata != '0)
		else $error("nondegenerate item with zero normal");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> vld_q[1] && m_tvalid && !m_tready)
		else $error("input stalled while pipeline has room");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[1])
		else $error("accepted item did not enter first stage");
`endif

endmodule
